// ===== hw/rtl/wnls_pkg.sv =====
package wnls_pkg;

    // Loop position counter width
    localparam int POS_BITS = 16;
    localparam int LEN_W    = POS_BITS + 1;

    // Register widths
    localparam int LL_W       = 16;
    localparam int STEP_W     = 24;
    localparam int GAIN_W     = 15;
    localparam int SEED_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Loop length compare width: holds the register and 2^POS_BITS
    localparam int CMP_W = (LEN_W > LL_W + 1) ? LEN_W : LL_W + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED_START = 2'd3;

    // Register reset values
    localparam logic [LL_W-1:0]   LOOP_LENGTH_RST = 16'd39690;
    localparam logic [STEP_W-1:0] FADE_STEP_RST   = 24'd16908;
    localparam logic [GAIN_W-1:0] GAIN_RST        = 15'd26000;
    localparam logic [SEED_W-1:0] SEED_RST        = 32'd4242;

    // Generator
    localparam logic [SEED_W-1:0] LCG_MUL = 32'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD = 32'd12345;

    // Datapath widths
    localparam int W_W     = 17;          // white noise, signed
    localparam int FILT_W  = 34;          // filter state and mix, signed
    localparam int PROD_W  = 33;          // white noise times coefficient
    localparam int WIDE_W  = FILT_W + 18; // filter state times coefficient
    localparam int FADE_W  = STEP_W + 1;
    localparam int FIN_W   = POS_BITS + STEP_W;
    localparam int FOUT_W  = LEN_W + STEP_W;
    localparam int MAG_W   = FILT_W;
    localparam int T_W     = MAG_W + GAIN_W - 16;
    localparam int DIV_SHIFT = 15;
    localparam int Q_W     = T_W + 1 - DIV_SHIFT;
    localparam int SMP_W   = 16;

    // Q.16 coefficients
    localparam logic signed [15:0] C_NEW   = 16'sd9830;
    localparam logic signed [17:0] C_OLD   = 18'sd55706;
    localparam logic signed [17:0] C_LOW   = 18'sd45875;
    localparam logic signed [15:0] C_WHITE = 16'sd19661;
    localparam logic signed [W_W-1:0] W_OFFSET = 17'sd32767;

    localparam logic [FADE_W-1:0] FADE_ONE = FADE_W'(1) << STEP_W;
    localparam logic [T_W:0]      DIVISOR  = (T_W+1)'((1 << DIV_SHIFT) - 1);

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic filt;
        logic mix;
        logic absv;
        logic fade;
        logic gain;
        logic qest;
        logic finish;
    } t_dp_cmd;

endpackage

// ===== hw/rtl/wnls_in_if.sv =====
interface wnls_in_if;
    import wnls_pkg::*;

    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// ===== hw/rtl/wnls_out_if.sv =====
interface wnls_out_if;
    import wnls_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;
    logic                    loop_end;

    modport source (output valid, output sample, output loop_end, input ready);
    modport sink   (input valid, input sample, input loop_end, output ready);
endinterface

// ===== hw/rtl/wnls_ctrl.sv =====
module wnls_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output wnls_pkg::t_dp_cmd o_cmd
);
    import wnls_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILT = 3'd1;
    localparam logic [2:0] S_MIX  = 3'd2;
    localparam logic [2:0] S_ABS  = 3'd3;
    localparam logic [2:0] S_FADE = 3'd4;
    localparam logic [2:0] S_GAIN = 3'd5;
    localparam logic [2:0] S_QEST = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                o_cmd.filt = 1'b1;
                n_state    = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = S_ABS;
            end
            S_ABS: begin
                o_cmd.absv = 1'b1;
                n_state    = S_FADE;
            end
            S_FADE: begin
                o_cmd.fade = 1'b1;
                n_state    = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = S_QEST;
            end
            S_QEST: begin
                o_cmd.qest = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/wnls_dp.sv =====
module wnls_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wnls_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wnls_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_restart,
    input  wnls_pkg::t_dp_cmd                   i_cmd,
    output logic signed [wnls_pkg::SMP_W-1:0]   o_sample,
    output logic                                o_loop_end
);
    import wnls_pkg::*;

    // Configuration
    logic [LL_W-1:0]   r_loop_length;
    logic [STEP_W-1:0] r_fade_step;
    logic [GAIN_W-1:0] r_gain;
    logic [SEED_W-1:0] r_seed_start;

    // Loop state
    logic [POS_BITS-1:0]     r_pos;
    logic [SEED_W-1:0]       r_seed;
    logic signed [FILT_W-1:0] r_filt;

    // Per-item working registers
    logic                     r_last;
    logic [FIN_W-1:0]         r_fin;
    logic [FOUT_W-1:0]        r_fout;
    logic signed [FILT_W-1:0] r_pold;
    logic signed [PROD_W-1:0] r_white;
    logic [FADE_W-1:0]        r_fade;
    logic signed [FILT_W-1:0] r_v;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_mag;
    logic [MAG_W-1:0]         r_amp;
    logic [T_W-1:0]           r_t;
    logic [Q_W-1:0]           r_q1;
    logic signed [SMP_W-1:0]  r_sample;
    logic                     r_loop_end;

    // Loop length, clipped
    logic [CMP_W-1:0] ll_ext;
    logic [LEN_W-1:0] len_eff;

    always_comb begin
        ll_ext = CMP_W'(r_loop_length);
        if (r_loop_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (ll_ext > (CMP_W'(1) << POS_BITS)) begin
            len_eff = LEN_W'(1) << POS_BITS;
        end else begin
            len_eff = LEN_W'(ll_ext);
        end
    end

    // Load: choose loop start or running state, step the generator
    logic                     restart_now;
    logic [POS_BITS-1:0]      sel_pos;
    logic [SEED_W-1:0]        sel_seed;
    logic signed [FILT_W-1:0] sel_filt;
    logic [SEED_W-1:0]        n_seed;
    logic signed [WIDE_W-1:0] p_old;
    logic [FIN_W-1:0]         n_fin;
    logic [FOUT_W-1:0]        n_fout;

    assign restart_now = i_restart || (LEN_W'(r_pos) >= len_eff);
    assign sel_pos     = restart_now ? '0 : r_pos;
    assign sel_seed    = restart_now ? r_seed_start : r_seed;
    assign sel_filt    = restart_now ? '0 : r_filt;
    assign n_seed      = sel_seed * LCG_MUL + LCG_ADD;
    assign p_old       = sel_filt * C_OLD;
    assign n_fin       = sel_pos * r_fade_step;
    assign n_fout      = (len_eff - LEN_W'(sel_pos)) * r_fade_step;

    // Filter step
    logic signed [W_W-1:0]    w;
    logic signed [PROD_W-1:0] t_new;
    logic signed [PROD_W-1:0] n_white;
    logic signed [FILT_W-1:0] n_filt;
    logic [FOUT_W-1:0]        fin_x;
    logic [FOUT_W-1:0]        fmin;
    logic [FADE_W-1:0]        n_fade;

    assign w       = $signed({1'b0, r_seed[30:16], 1'b0}) - W_OFFSET;
    assign t_new   = w * C_NEW;
    assign n_white = w * C_WHITE;
    assign n_filt  = {{(FILT_W-PROD_W){t_new[PROD_W-1]}}, t_new} + r_pold;
    assign fin_x   = FOUT_W'(r_fin);
    assign fmin    = (fin_x < r_fout) ? fin_x : r_fout;
    assign n_fade  = (fmin > FOUT_W'(FADE_ONE)) ? FADE_ONE : fmin[FADE_W-1:0];

    // Mix
    logic signed [WIDE_W-1:0] p_mix;
    logic signed [FILT_W-1:0] n_v;

    assign p_mix = r_filt * C_LOW;
    assign n_v   = p_mix[FILT_W+15:16]
                 + {{(FILT_W-PROD_W){r_white[PROD_W-1]}}, r_white};

    // Fade and gain
    logic [MAG_W+FADE_W-1:0] p_fade;
    logic [MAG_W+GAIN_W-1:0] p_gain;

    assign p_fade = r_mag * r_fade;
    assign p_gain = r_amp * r_gain;

    // Divide by 2^15-1: estimate, then one correction
    logic [T_W:0]    q_sum;
    logic [T_W:0]    q1_x;
    logic [T_W:0]    rem;
    logic [Q_W-1:0]  q;
    logic [Q_W-1:0]  smp_full;

    assign q_sum    = {1'b0, r_t} + (T_W+1)'(r_t >> DIV_SHIFT)
                    + (T_W+1)'(r_t >> (2 * DIV_SHIFT));
    assign q1_x     = (T_W+1)'(r_q1);
    assign rem      = {1'b0, r_t} - ((q1_x << DIV_SHIFT) - q1_x);
    assign q        = (rem >= DIVISOR) ? r_q1 + Q_W'(1) : r_q1;
    assign smp_full = r_neg ? (Q_W'(0) - q) : q;

    // Configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_length <= LOOP_LENGTH_RST;
            r_fade_step   <= FADE_STEP_RST;
            r_gain        <= GAIN_RST;
            r_seed_start  <= SEED_RST;
            r_pos         <= '0;
            r_seed        <= SEED_RST;
            r_filt        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LOOP_LENGTH:      r_loop_length <= i_cfg_data[LL_W-1:0];
                    REG_FADE_STEP:        r_fade_step   <= i_cfg_data[STEP_W-1:0];
                    REG_OUTPUT_GAIN:      r_gain        <= i_cfg_data[GAIN_W-1:0];
                    REG_NOISE_SEED_START: r_seed_start  <= i_cfg_data[SEED_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_pos  <= sel_pos;
                r_seed <= n_seed;
            end
            if (i_cmd.filt) begin
                r_filt <= n_filt;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_pos  <= '0;
                    r_seed <= r_seed_start;
                    r_filt <= '0;
                end else begin
                    r_pos <= r_pos + POS_BITS'(1);
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= (LEN_W'(sel_pos) == (len_eff - LEN_W'(1)));
            r_fin  <= n_fin;
            r_fout <= n_fout;
            r_pold <= p_old[FILT_W+15:16];
        end
        if (i_cmd.filt) begin
            r_white <= n_white;
            r_fade  <= n_fade;
        end
        if (i_cmd.mix) begin
            r_v <= n_v;
        end
        if (i_cmd.absv) begin
            r_neg <= r_v[FILT_W-1];
            r_mag <= r_v[FILT_W-1] ? MAG_W'(-r_v) : MAG_W'(r_v);
        end
        if (i_cmd.fade) begin
            r_amp <= p_fade[MAG_W+STEP_W-1:STEP_W];
        end
        if (i_cmd.gain) begin
            r_t <= p_gain[MAG_W+GAIN_W-1:16];
        end
        if (i_cmd.qest) begin
            r_q1 <= q_sum[T_W:DIV_SHIFT];
        end
        if (i_cmd.finish) begin
            r_sample   <= smp_full[SMP_W-1:0];
            r_loop_end <= r_last;
        end
    end

    assign o_sample   = r_sample;
    assign o_loop_end = r_loop_end;

endmodule

// ===== hw/rtl/wind_noise_loop_synth_top.sv =====
// Channel  Dir  Payload                      Accepted when
// i_in     in   restart (1)                  valid && ready
// o_out    out  sample (16 signed), loop_end valid && ready
// i_cfg    in   idx (2), data (32)           i_cfg_we high
//
// Each item walks these steps from acceptance to a loaded output register: load
// (generator step, old filter term, both fade ramps), filter, mix, magnitude, fade,
// gain, quotient estimate and finish; a new item is taken only once the last finishes.
// Reset is synchronous, active low: register reset values, position zero, filter clear.
// The next item is taken while a result waits; finish holds while the output
// register is full and not being taken.
module wind_noise_loop_synth_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wnls_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wnls_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    wnls_in_if.sink                           i_in,
    wnls_out_if.source                        o_out
);
    import wnls_pkg::*;

    t_dp_cmd cmd;
    logic    in_ready;
    logic    out_valid;

    // Sequencer: walks one item through the datapath steps
    wnls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // Datapath: generator, lowpass, mix, fade, gain, output register
    wnls_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_restart  (i_in.restart),
        .i_cmd      (cmd),
        .o_sample   (o_out.sample),
        .o_loop_end (o_out.loop_end)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

// ===== hw/rtl/wnls_chk.sv =====
module wnls_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic signed [wnls_pkg::SMP_W-1:0] i_sample,
    input logic                            i_loop_end
);
    import wnls_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // Output holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_sample) && $stable(i_loop_end))
        else $error("output payload changed while stalled");

    // One item in flight: no second item straight after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input taken while an item is in flight");

    // With the output register free at the finish step, the result follows
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##7 (!i_out_valid || i_out_ready) |=> i_out_valid)
        else $error("no result eight cycles after an accepted item");

endmodule

bind wind_noise_loop_synth_top wnls_chk u_wnls_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sample    (o_out.sample),
    .i_loop_end  (o_out.loop_end)
);
